// File: rtl/csl_pkg.sv
// Package for the C subset lexer: constants, scan modes and classification functions.
package csl_pkg;

  localparam int LINE_BITS   = 20;
  localparam int OFFSET_BITS = 24;
  localparam int MAX_LEN     = 255;
  localparam int LEN_BITS    = 9;

  localparam logic [5:0] K_INTLIT   = 6'd18;
  localparam logic [5:0] K_FLOATLIT = 6'd19;
  localparam logic [5:0] K_CHARLIT  = 6'd20;
  localparam logic [5:0] K_STRLIT   = 6'd21;
  localparam logic [5:0] K_IDENT    = 6'd22;
  localparam logic [5:0] K_END      = 6'd61;
  localparam logic [5:0] K_UNKNOWN  = 6'd62;
  localparam logic [5:0] K_NONE     = 6'd0;

  typedef enum logic [10:0] {
    M_IDLE      = 11'b00000000001,
    M_IDENT     = 11'b00000000010,
    M_INT       = 11'b00000000100,
    M_FRAC      = 11'b00000001000,
    M_STR       = 11'b00000010000,
    M_CHR_OPEN  = 11'b00000100000,
    M_CHR_CLOSE = 11'b00001000000,
    M_HELD      = 11'b00010000000,
    M_LCOM      = 11'b00100000000,
    M_BCOM      = 11'b01000000000,
    M_BSTAR     = 11'b10000000000
  } mode_t;

  typedef struct packed {
    logic                   vld;
    logic [5:0]             kind;
    logic [LINE_BITS-1:0]   line;
    logic [OFFSET_BITS-1:0] start;
    logic [LEN_BITS-1:0]    len;
  } tok_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] h);
    logic [5:0] k;
    k = K_UNKNOWN;
    case (h)
      "+": k = 6'd23;
      "-": k = 6'd24;
      "*": k = 6'd25;
      "/": k = 6'd26;
      "=": k = 6'd30;
      "!": k = 6'd43;
      "<": k = 6'd37;
      ">": k = 6'd38;
      "&": k = 6'd44;
      "|": k = 6'd45;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
    logic [5:0] k;
    k = K_NONE;
    case (h)
      "+": k = (c == "+") ? 6'd28 : (c == "=") ? 6'd31 : K_NONE;
      "-": k = (c == "-") ? 6'd29 : (c == "=") ? 6'd32 : (c == ">") ? 6'd50 : K_NONE;
      "*": k = (c == "=") ? 6'd33 : K_NONE;
      "/": k = (c == "=") ? 6'd34 : K_NONE;
      "=": k = (c == "=") ? 6'd35 : K_NONE;
      "!": k = (c == "=") ? 6'd36 : K_NONE;
      "<": k = (c == "=") ? 6'd39 : (c == "<") ? 6'd48 : K_NONE;
      ">": k = (c == "=") ? 6'd40 : (c == ">") ? 6'd49 : K_NONE;
      "&": k = (c == "&") ? 6'd41 : K_NONE;
      "|": k = (c == "|") ? 6'd42 : K_NONE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] lone_kind(input logic [7:0] c);
    logic [5:0] k;
    k = K_UNKNOWN;
    case (c)
      "%": k = 6'd27;
      "^": k = 6'd46;
      "~": k = 6'd47;
      "(": k = 6'd51;
      ")": k = 6'd52;
      "{": k = 6'd53;
      "}": k = 6'd54;
      "[": k = 6'd55;
      "]": k = 6'd56;
      ";": k = 6'd57;
      ",": k = 6'd58;
      ".": k = 6'd59;
      ":": k = 6'd60;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  // Keyword match on the first eight bytes packed right-aligned, plus exact length.
  function automatic logic [5:0] ident_kind(input logic [63:0] p, input logic [LEN_BITS-1:0] n);
    logic [5:0] k;
    k = K_IDENT;
    if      (n == 9'd3 && p == 64'h696e74)             k = 6'd0;
    else if (n == 9'd4 && p == 64'h766f6964)           k = 6'd1;
    else if (n == 9'd6 && p == 64'h72657475726e)       k = 6'd2;
    else if (n == 9'd2 && p == 64'h6966)               k = 6'd3;
    else if (n == 9'd4 && p == 64'h656c7365)           k = 6'd4;
    else if (n == 9'd5 && p == 64'h7768696c65)         k = 6'd5;
    else if (n == 9'd3 && p == 64'h666f72)             k = 6'd6;
    else if (n == 9'd5 && p == 64'h627265616b)         k = 6'd7;
    else if (n == 9'd8 && p == 64'h636f6e74696e7565)   k = 6'd8;
    else if (n == 9'd4 && p == 64'h63686172)           k = 6'd9;
    else if (n == 9'd5 && p == 64'h666c6f6174)         k = 6'd10;
    else if (n == 9'd6 && p == 64'h646f75626c65)       k = 6'd11;
    else if (n == 9'd4 && p == 64'h6c6f6e67)           k = 6'd12;
    else if (n == 9'd5 && p == 64'h73686f7274)         k = 6'd13;
    else if (n == 9'd8 && p == 64'h756e7369676e6564)   k = 6'd14;
    else if (n == 9'd6 && p == 64'h7369676e6564)       k = 6'd15;
    else if (n == 9'd6 && p == 64'h737472756374)       k = 6'd16;
    else if (n == 9'd6 && p == 64'h73697a656f66)       k = 6'd17;
    return k;
  endfunction

endpackage

// File: rtl/c_subset_lexer.sv
// Top level of the C subset lexer: scan state, token formation and output queue.
//
//  channel | ports                                          | direction
//  input   | in_valid in_ready in_source_byte in_end_of_input | in
//  output  | out_valid out_ready out_token_kind out_token_line | out
//          | out_value_start out_value_length out_truncated out_last |
//
// One byte is taken per cycle while the queue has room; its tokens (up to two) are formed in that cycle and
// written into a four-entry output queue. Each token leaves in its own output transfer,
// so a byte that yields two tokens takes two output transfers.
// Input is taken whenever the queue has room for two more tokens.
// Reset (synchronous, rst_n low) empties the queue and returns the scanner to idle.
module c_subset_lexer import csl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_source_byte,
  input  logic                   in_end_of_input,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [5:0]             out_token_kind,
  output logic [LINE_BITS-1:0]   out_token_line,
  output logic [OFFSET_BITS-1:0] out_value_start,
  output logic [7:0]             out_value_length,
  output logic                   out_truncated,
  output logic                   out_last
);

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  mode_t                  mode_r, mode_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] tstart_r, tstart_nxt;
  logic [LINE_BITS-1:0]   tline_r, tline_nxt;
  logic [LEN_BITS-1:0]    tlen_r, tlen_nxt;
  logic [63:0]            pfx_r, pfx_nxt;
  logic                   esc_r, esc_nxt;

  tok_t t0, t1;
  tok_t q_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r;
  logic       acc, pop;
  logic [7:0] c;
  logic [5:0] pk;
  logic       do_begin;
  logic [LEN_BITS-1:0] grown;

  assign c     = in_source_byte;
  assign acc   = in_valid && in_ready;
  assign pop   = out_valid && out_ready;
  assign in_ready = (cnt_r <= 3'd2);
  assign grown = (tlen_r <= LEN_BITS'(MAX_LEN)) ? tlen_r + 1'b1 : tlen_r;

  function automatic tok_t mk(input logic [5:0] k, input logic [LINE_BITS-1:0] l,
                              input logic [OFFSET_BITS-1:0] s, input logic [LEN_BITS-1:0] n);
    tok_t t;
    t.vld = 1'b1; t.kind = k; t.line = l; t.start = s; t.len = n;
    return t;
  endfunction

  always_comb begin
    mode_nxt = mode_r; held_nxt = held_r; line_nxt = line_r; off_nxt = off_r;
    tstart_nxt = tstart_r; tline_nxt = tline_r; tlen_nxt = tlen_r; pfx_nxt = pfx_r;
    esc_nxt = esc_r;
    t0 = '0; t1 = '0;
    do_begin = 1'b0;
    pk = pair_kind(held_r, c);
    if (in_end_of_input) begin
      unique case (mode_r)
        M_IDENT:  t0 = mk(ident_kind(pfx_r, tlen_r), tline_r, tstart_r, tlen_r);
        M_INT:    t0 = mk(K_INTLIT, tline_r, tstart_r, tlen_r);
        M_FRAC:   t0 = mk(K_FLOATLIT, tline_r, tstart_r, tlen_r);
        M_STR:    t0 = mk(K_STRLIT, tline_r, tstart_r, tlen_r);
        M_CHR_OPEN, M_CHR_CLOSE: t0 = mk(K_CHARLIT, tline_r, tstart_r, tlen_r);
        M_HELD:   t0 = mk(single_kind(held_r), tline_r, tstart_r, tlen_r);
        default: ;
      endcase
      if (t0.vld) t1 = mk(K_END, line_r, off_r, '0);
      else        t0 = mk(K_END, line_r, off_r, '0);
      mode_nxt = M_IDLE;
      esc_nxt  = 1'b0;
    end else begin
      off_nxt = off_r + 1'b1;
      unique case (mode_r)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (tlen_r < 9'd8) pfx_nxt = {pfx_r[55:0], c};
            tlen_nxt = grown;
          end else begin
            t0 = mk(ident_kind(pfx_r, tlen_r), tline_r, tstart_r, tlen_r);
            do_begin = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c)) tlen_nxt = grown;
          else if (c == ".") begin
            tlen_nxt = grown; mode_nxt = M_FRAC;
          end else begin
            t0 = mk(K_INTLIT, tline_r, tstart_r, tlen_r); do_begin = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) tlen_nxt = grown;
          else begin
            t0 = mk(K_FLOATLIT, tline_r, tstart_r, tlen_r); do_begin = 1'b1;
          end
        end
        M_STR: begin
          if (esc_r) begin
            tlen_nxt = grown; esc_nxt = 1'b0;
          end else if (c == 8'h22) begin
            t0 = mk(K_STRLIT, tline_r, tstart_r, tlen_r); mode_nxt = M_IDLE;
          end else begin
            tlen_nxt = grown; esc_nxt = (c == 8'h5c);
          end
        end
        M_CHR_OPEN: begin
          tlen_nxt = grown;
          if (!esc_r && c == 8'h5c) esc_nxt = 1'b1;
          else begin
            esc_nxt = 1'b0; mode_nxt = M_CHR_CLOSE;
          end
        end
        M_CHR_CLOSE: begin
          t0 = mk(K_CHARLIT, tline_r, tstart_r, tlen_r);
          if (c == 8'h27) mode_nxt = M_IDLE;
          else do_begin = 1'b1;
        end
        M_HELD: begin
          if (held_r == "/" && c == "/") mode_nxt = M_LCOM;
          else if (held_r == "/" && c == "*") mode_nxt = M_BCOM;
          else if (pk != K_NONE) begin
            tlen_nxt = 9'd2;
            t0 = mk(pk, tline_r, tstart_r, 9'd2);
            mode_nxt = M_IDLE;
          end else begin
            t0 = mk(single_kind(held_r), tline_r, tstart_r, tlen_r);
            do_begin = 1'b1;
          end
        end
        M_LCOM: begin
          if (c == 8'h0a) begin
            if (line_r != LINE_MAX) line_nxt = line_r + 1'b1;
            mode_nxt = M_IDLE;
          end
        end
        M_BCOM, M_BSTAR: begin
          if (mode_r == M_BSTAR && c == "/") mode_nxt = M_IDLE;
          else if (c == "*") mode_nxt = M_BSTAR;
          else begin
            if (c == 8'h0a && line_r != LINE_MAX) line_nxt = line_r + 1'b1;
            mode_nxt = M_BCOM;
          end
        end
        default: do_begin = 1'b1;
      endcase
      // A byte that may start a new token; may emit a lone token after a closed one.
      if (do_begin) begin
        mode_nxt = M_IDLE; esc_nxt = 1'b0;
        tline_nxt = line_r; tstart_nxt = off_r; tlen_nxt = 9'd1;
        if (c == 8'h0a) begin
          if (line_r != LINE_MAX) line_nxt = line_r + 1'b1;
        end else if (c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d) begin
        end else if (is_alpha(c)) begin
          mode_nxt = M_IDENT; pfx_nxt = {56'd0, c};
        end else if (is_digit(c)) begin
          mode_nxt = M_INT;
        end else if (c == 8'h22 || c == 8'h27) begin
          mode_nxt = (c == 8'h22) ? M_STR : M_CHR_OPEN;
          tstart_nxt = off_r + 1'b1; tlen_nxt = '0;
        end else if (single_kind(c) != K_UNKNOWN) begin
          mode_nxt = M_HELD; held_nxt = c;
        end else if (t0.vld) begin
          t1 = mk(lone_kind(c), line_r, off_r, 9'd1);
        end else begin
          t0 = mk(lone_kind(c), line_r, off_r, 9'd1);
        end
      end
    end
  end

  // The last flag is set on the final token of a byte when it enters the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; held_r <= '0; line_r <= LINE_BITS'(1); off_r <= '0;
      tstart_r <= '0; tline_r <= LINE_BITS'(1); tlen_r <= '0; pfx_r <= '0; esc_r <= 1'b0;
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      logic [2:0] n;
      n = 3'd0;
      if (acc) begin
        mode_r <= mode_nxt; held_r <= held_nxt; line_r <= line_nxt; off_r <= off_nxt;
        tstart_r <= tstart_nxt; tline_r <= tline_nxt; tlen_r <= tlen_nxt;
        pfx_r <= pfx_nxt; esc_r <= esc_nxt;
        if (t0.vld) begin
          q_r[wr_r] <= t0;
          n = 3'd1;
        end
        if (t1.vld) begin
          q_r[wr_r + 2'd1] <= t1;
          n = 3'd2;
        end
      end
      wr_r  <= wr_r + n[1:0];
      rd_r  <= rd_r + {1'b0, pop};
      cnt_r <= cnt_r + n - {2'b0, pop};
    end
  end

  // The last mark is kept beside the queue, one bit per entry.
  logic last_bit [4];
  always_ff @(posedge clk) begin
    if (acc) begin
      if (t0.vld) last_bit[wr_r] <= !t1.vld;
      if (t1.vld) last_bit[wr_r + 2'd1] <= 1'b1;
    end
  end

  tok_t head;
  assign head            = q_r[rd_r];
  assign out_valid       = (cnt_r != 3'd0);
  assign out_token_kind  = head.kind;
  assign out_token_line  = head.line;
  assign out_value_start = head.start;
  assign out_value_length = (head.len > LEN_BITS'(MAX_LEN)) ? 8'(MAX_LEN) : head.len[7:0];
  assign out_truncated   = (head.len > LEN_BITS'(MAX_LEN));
  assign out_last        = last_bit[rd_r];

endmodule
